@@ hdl/tdq_pkg.sv @@
// Package for the timed release delay queue.
// Holds item, result and ring-entry types plus operation and status codes.
// No dependencies.
package tdq_pkg;

  // Operation codes carried by an input item
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POLL = 1'b1;

  // Result status codes
  localparam logic ST_RELEASE = 1'b0;
  localparam logic ST_DROP    = 1'b1;

  // Timestamp and payload widths
  localparam int TimeW = 32;
  localparam int PayW  = 64;

  typedef struct packed {
    logic             operation;
    logic [TimeW-1:0] now_time;
    logic [PayW-1:0]  payload;
  } item_t;

  typedef struct packed {
    logic [PayW-1:0] out_payload;
    logic            status;
    logic            last;
  } result_t;

  // One ring slot: push timestamp and stored payload
  typedef struct packed {
    logic [TimeW-1:0] stamp;
    logic [PayW-1:0]  payload;
  } entry_t;

  localparam int EntryW = TimeW + PayW;

endpackage

@@ hdl/timed_release_delay_queue_unit.sv @@
// Timed release delay queue: ring of timestamped payloads released after a delay.
// Depends on tdq_pkg and tdq_ram (one ring memory holding stamp and payload).
//
//   port group        direction  handshake
//   item_i            in         start_i high and busy_o low at the clock edge
//   result_o          out        result_valid_o high for one cycle, no backpressure
//   cfg_wdata_i       in         cfg_we_i high at the clock edge (delay_ticks)
//
// A push leaves busy_o low; only a push into a full ring gives a result, a drop
// result that appears in the cycle after the transfer. A poll holds busy_o while
// it releases 0 to MAX_RELEASE entries; a poll on an empty ring leaves it low.
// Results of a poll come out at one per cycle, set by the single read port of the
// ring memory; each entry the ring read returns is held in pend_q and then
// registered in res_q (the newest release is held in pend_q until it is known
// whether it is the last). Reset clears pointers and delay; the ring contents
// need no clearing. The receiver cannot stall the results.
module timed_release_delay_queue_unit #(
  parameter int DEPTH       = 1024,
  parameter int MAX_RELEASE = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  tdq_pkg::item_t        item_i,
  output logic                  result_valid_o,
  output tdq_pkg::result_t      result_o,
  input  logic                  cfg_we_i,
  input  logic [31:0]           cfg_wdata_i
);
  import tdq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(MAX_RELEASE + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POLL,
    S_FLUSH
  } state_e;

  state_e           state_q;
  logic [AW-1:0]    rd_q, wr_q;
  logic [TimeW-1:0] delay_q, now_q;
  logic [CW-1:0]    cnt_q;
  logic             pend_valid_q;
  logic [PayW-1:0]  pend_q;
  logic             res_valid_q;
  result_t          res_q;

  logic             accept;
  logic [AW-1:0]    rd_next, wr_next, scan_next;
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_raddr;
  entry_t           wentry, rentry;
  logic [TimeW-1:0] elapsed;
  logic             due;
  logic [CW-1:0]    cnt_inc;
  logic             stop_after;

  // Ring index increment with wrap at DEPTH
  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
    logic [AW-1:0] r;
    if (i == AW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + 1'b1;
    end
    return r;
  endfunction

  assign accept    = start_i && !busy_o;
  assign busy_o    = (state_q != S_IDLE);
  assign rd_next   = next_slot(rd_q);
  assign wr_next   = next_slot(wr_q);
  assign scan_next = next_slot(rd_next);

  // Entry under test during a poll is the slot after rd_q
  assign elapsed    = now_q - rentry.stamp;
  assign due        = (elapsed > delay_q);
  assign cnt_inc    = cnt_q + 1'b1;
  assign stop_after = (rd_next == wr_q) || (cnt_inc == CW'(MAX_RELEASE));

  // Ring memory access: pushes write, polls read one slot ahead
  always_comb begin
    ram_we    = accept && (item_i.operation == OP_PUSH) && (wr_next != rd_q);
    ram_re    = 1'b0;
    ram_raddr = rd_next;
    if (state_q == S_IDLE) begin
      ram_re    = accept && (item_i.operation == OP_POLL) && (rd_q != wr_q);
      ram_raddr = rd_next;
    end else if (state_q == S_POLL) begin
      ram_re    = due && !stop_after;
      ram_raddr = scan_next;
    end
  end

  assign wentry.stamp   = item_i.now_time;
  assign wentry.payload = item_i.payload;

  tdq_ram #(
    .WIDTH (EntryW),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_next),
    .wdata_i (wentry),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rentry)
  );

  // Control state, pointers and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      rd_q         <= '0;
      wr_q         <= '0;
      delay_q      <= '0;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      if (cfg_we_i) begin
        delay_q <= cfg_wdata_i;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (item_i.operation == OP_PUSH) begin
              if (wr_next == rd_q) begin
                // full ring: reject the transfer
                res_valid_q       <= 1'b1;
                res_q.out_payload <= item_i.payload;
                res_q.status      <= ST_DROP;
                res_q.last        <= 1'b1;
              end else begin
                wr_q <= wr_next;
              end
            end else begin
              now_q        <= item_i.now_time;
              cnt_q        <= '0;
              pend_valid_q <= 1'b0;
              if (rd_q != wr_q) begin
                state_q <= S_POLL;
              end
            end
          end
        end
        S_POLL: begin
          if (due) begin
            // hold newest release until we know whether it is the last
            if (pend_valid_q) begin
              res_valid_q       <= 1'b1;
              res_q.out_payload <= pend_q;
              res_q.status      <= ST_RELEASE;
              res_q.last        <= 1'b0;
            end
            pend_q       <= rentry.payload;
            pend_valid_q <= 1'b1;
            rd_q         <= rd_next;
            cnt_q        <= cnt_inc;
            if (stop_after) begin
              state_q <= S_FLUSH;
            end
          end else begin
            if (pend_valid_q) begin
              res_valid_q       <= 1'b1;
              res_q.out_payload <= pend_q;
              res_q.status      <= ST_RELEASE;
              res_q.last        <= 1'b1;
            end
            pend_valid_q <= 1'b0;
            state_q      <= S_IDLE;
          end
        end
        S_FLUSH: begin
          res_valid_q       <= 1'b1;
          res_q.out_payload <= pend_q;
          res_q.status      <= ST_RELEASE;
          res_q.last        <= 1'b1;
          pend_valid_q      <= 1'b0;
          state_q           <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

`ifndef NO_ASSERTIONS
  // A drop result only follows a push transfer
  a_drop_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.status == ST_DROP) |->
      $past(accept && item_i.operation == OP_PUSH))
    else $error("drop result without a push transfer");

  // Release count never passes the per-poll limit
  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_RELEASE))
    else $error("release count above limit");

  // Flush always has a held release to deliver
  a_flush_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH) |-> pend_valid_q)
    else $error("flush without held release");

  // Ring is never written while a poll is scanning it
  a_no_write_in_poll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !ram_we)
    else $error("ring write during poll");

  // Pointers stay inside the ring
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_q <= AW'(DEPTH - 1)) && (wr_q <= AW'(DEPTH - 1)))
    else $error("ring pointer out of range");
`endif

endmodule

@@ hdl/tdq_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tdq_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
